FILE: design/xml_markup_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
`ifndef XML_MARKUP_TOKENIZER_ASSERT_SVH
`define XML_MARKUP_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, masked while reset is held.
`define XMT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Check a property on every rising edge, reset included.
`define XMT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define XMT_ASSERT(label, clk, rst_n, prop)
`define XMT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: design/xmt_pkg.sv
// Types and character constants for the markup tokenizer.
package xmt_pkg;

    typedef enum logic [13:0] {
        ST_TEXT  = 14'h0001,
        ST_LT    = 14'h0002,
        ST_DNAME = 14'h0004,
        ST_ENAME = 14'h0008,
        ST_SNAME = 14'h0010,
        ST_AWS   = 14'h0020,
        ST_KEY   = 14'h0040,
        ST_KWS   = 14'h0080,
        ST_EWS   = 14'h0100,
        ST_QVAL  = 14'h0200,
        ST_UVAL  = 14'h0400,
        ST_POST  = 14'h0800,
        ST_SLASH = 14'h1000,
        ST_DTAIL = 14'h2000
    } t_pstate;

    typedef enum logic [3:0] {
        K_TEXT     = 4'd0,
        K_TEXT_END = 4'd1,
        K_NAME     = 4'd2,
        K_KEY      = 4'd3,
        K_VALUE    = 4'd4,
        K_ATTR_END = 4'd5,
        K_START    = 4'd6,
        K_EMPTY    = 4'd7,
        K_ENDTAG   = 4'd8,
        K_DECL     = 4'd9
    } t_kind;

    typedef struct packed {
        t_pstate pstate;
        logic    text_pending;
        logic    key_pending;
        logic    quote_is_single;
        logic    in_declaration;
    } t_ctx;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [1:0]           n;
        t_res [MAX_RES-1:0]   r;
    } t_batch;

    localparam t_ctx CTX_RESET = '{
        pstate: ST_TEXT, text_pending: 1'b0, key_pending: 1'b0,
        quote_is_single: 1'b0, in_declaration: 1'b0
    };

    localparam logic [7:0] C_LT = 8'h3C;
    localparam logic [7:0] C_QM = 8'h3F;
    localparam logic [7:0] C_SL = 8'h2F;
    localparam logic [7:0] C_GT = 8'h3E;
    localparam logic [7:0] C_EQ = 8'h3D;
    localparam logic [7:0] C_DQ = 8'h22;
    localparam logic [7:0] C_SQ = 8'h27;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

FILE: design/xml_markup_tokenizer.sv
// Each byte is registered at input; its tokens are then registered in the result buffer.
// Throughput: one byte per cycle while each byte gives at most one token and the output
// is ready; a byte giving n tokens holds the result buffer until its single read port
// has handed out all n. Bytes with no token pass at one per cycle while the buffer is free.
// Reset (synchronous, active low) returns the parser to text state and empties both stages.
`include "xml_markup_tokenizer_assert.svh"
module xml_markup_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import xmt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    t_ctx       r_ctx;
    t_ctx       n_ctx;
    t_batch     batch;
    t_res       head;
    logic       can_load;
    logic       proc;

    assign proc    = r_in_valid && can_load;
    assign o_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_ctx      <= CTX_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (proc) begin
                r_ctx <= n_ctx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    xmt_step u_step (
        .i_ctx   (r_ctx),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_ctx   (n_ctx),
        .o_batch (batch)
    );

    xmt_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (proc),
        .i_batch    (batch),
        .i_ready    (i_ready),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .o_res      (head),
        .o_last     (o_last)
    );

    assign o_token_kind = head.kind;
    assign o_out_byte   = head.data;

    `XMT_ASSERT(a_kind_range, i_clk, i_rst_n, o_valid |-> (o_token_kind <= K_DECL))
    `XMT_ASSERT(a_mark_no_byte, i_clk, i_rst_n, (o_valid && (o_token_kind == K_TEXT_END || o_token_kind >= K_ATTR_END)) |-> (o_out_byte == 8'h00))
    `XMT_ASSERT(a_batch_runs_on, i_clk, i_rst_n, (o_valid && i_ready && !o_last) |=> o_valid)
    `XMT_ASSERT(a_hold_until_drained, i_clk, i_rst_n, (r_in_valid && o_valid && !(o_last && i_ready)) |=> r_in_valid)
    `XMT_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (!o_valid && !r_in_valid))

endmodule

FILE: design/xmt_step.sv
// Per-byte parser: next context and up to three tokens from one byte.
module xmt_step (
    input  xmt_pkg::t_ctx   i_ctx,
    input  logic [7:0]      i_byte,
    input  logic            i_eos,
    output xmt_pkg::t_ctx   o_ctx,
    output xmt_pkg::t_batch o_batch
);
    import xmt_pkg::*;

    t_ctx                 ctx;
    logic [1:0]           n;
    t_res [MAX_RES-1:0]   res;
    logic                 done;
    logic                 e_v;
    t_kind                e_kind;
    logic [7:0]           e_byte;
    logic                 ws;

    assign ws = is_ws(i_byte);

    always_comb begin
        ctx    = i_ctx;
        n      = 2'd0;
        res    = '0;
        done   = 1'b0;
        e_v    = 1'b0;
        e_kind = K_TEXT;
        e_byte = 8'h00;
        if (i_eos) begin
            res[0].data = 8'h00;
            case (i_ctx.pstate)
                ST_TEXT: begin
                    if (i_ctx.text_pending) begin
                        res[0].kind = K_TEXT_END;
                        n = 2'd1;
                    end
                end
                ST_LT, ST_SNAME: begin
                    res[0].kind = K_START;
                    n = 2'd1;
                end
                ST_DNAME, ST_DTAIL: begin
                    res[0].kind = K_DECL;
                    n = 2'd1;
                end
                ST_ENAME: begin
                    res[0].kind = K_ENDTAG;
                    n = 2'd1;
                end
                ST_SLASH: begin
                    res[0].kind = K_EMPTY;
                    n = 2'd1;
                end
                default: begin
                    if (i_ctx.key_pending) begin
                        res[0].kind = K_ATTR_END;
                        res[1].kind = i_ctx.in_declaration ? K_DECL : K_START;
                        n = 2'd2;
                    end else begin
                        res[0].kind = i_ctx.in_declaration ? K_DECL : K_START;
                        n = 2'd1;
                    end
                end
            endcase
            ctx = CTX_RESET;
        end else begin
            // Follow the state chain for this byte; eight passes at most.
            for (int g = 0; g < 8; g++) begin
                if (!done) begin
                    done   = 1'b1;
                    e_v    = 1'b0;
                    e_kind = K_TEXT;
                    e_byte = 8'h00;
                    case (ctx.pstate)
                        ST_TEXT: begin
                            if (i_byte == C_LT) begin
                                if (ctx.text_pending) begin
                                    e_v = 1'b1;
                                    e_kind = K_TEXT_END;
                                end
                                ctx.text_pending = 1'b0;
                                ctx.pstate = ST_LT;
                            end else begin
                                e_v = 1'b1;
                                e_kind = K_TEXT;
                                e_byte = i_byte;
                                ctx.text_pending = 1'b1;
                            end
                        end
                        ST_LT: begin
                            if (i_byte == C_QM) begin
                                ctx.in_declaration = 1'b1;
                                ctx.pstate = ST_DNAME;
                            end else if (i_byte == C_SL) begin
                                ctx.pstate = ST_ENAME;
                            end else begin
                                ctx.in_declaration = 1'b0;
                                ctx.pstate = ST_SNAME;
                                done = 1'b0;
                            end
                        end
                        ST_DNAME: begin
                            if (ws || i_byte == C_QM) begin
                                ctx.pstate = ST_AWS;
                                done = 1'b0;
                            end else begin
                                e_v = 1'b1;
                                e_kind = K_NAME;
                                e_byte = i_byte;
                            end
                        end
                        ST_ENAME: begin
                            if (i_byte == C_GT) begin
                                e_v = 1'b1;
                                e_kind = K_ENDTAG;
                                ctx.pstate = ST_TEXT;
                            end else if (!ws) begin
                                e_v = 1'b1;
                                e_kind = K_NAME;
                                e_byte = i_byte;
                            end
                        end
                        ST_SNAME: begin
                            if (ws || i_byte == C_GT || i_byte == C_SL) begin
                                ctx.pstate = ST_AWS;
                                done = 1'b0;
                            end else begin
                                e_v = 1'b1;
                                e_kind = K_NAME;
                                e_byte = i_byte;
                            end
                        end
                        ST_AWS: begin
                            if (!ws) begin
                                if (i_byte == C_GT || i_byte == C_QM || i_byte == C_SL) begin
                                    ctx.pstate = ctx.in_declaration ? ST_DTAIL : ST_POST;
                                end else begin
                                    ctx.key_pending = 1'b0;
                                    ctx.pstate = ST_KEY;
                                end
                                done = 1'b0;
                            end
                        end
                        ST_KEY: begin
                            if (ws || i_byte == C_EQ || i_byte == C_GT
                                    || i_byte == C_SL || i_byte == C_QM) begin
                                ctx.pstate = ST_KWS;
                                done = 1'b0;
                            end else begin
                                e_v = 1'b1;
                                e_kind = K_KEY;
                                e_byte = i_byte;
                                ctx.key_pending = 1'b1;
                            end
                        end
                        ST_KWS: begin
                            if (!ws) begin
                                if (i_byte == C_EQ) begin
                                    ctx.pstate = ST_EWS;
                                end else begin
                                    e_v = ctx.key_pending;
                                    e_kind = K_ATTR_END;
                                    ctx.key_pending = 1'b0;
                                    ctx.pstate = ST_AWS;
                                    done = 1'b0;
                                end
                            end
                        end
                        ST_EWS: begin
                            if (!ws) begin
                                if (i_byte == C_DQ || i_byte == C_SQ) begin
                                    ctx.quote_is_single = (i_byte == C_SQ);
                                    ctx.pstate = ST_QVAL;
                                end else begin
                                    ctx.pstate = ST_UVAL;
                                    done = 1'b0;
                                end
                            end
                        end
                        ST_QVAL: begin
                            if (i_byte == (ctx.quote_is_single ? C_SQ : C_DQ)) begin
                                e_v = ctx.key_pending;
                                e_kind = K_ATTR_END;
                                ctx.key_pending = 1'b0;
                                ctx.pstate = ST_AWS;
                            end else if (ctx.key_pending) begin
                                e_v = 1'b1;
                                e_kind = K_VALUE;
                                e_byte = i_byte;
                            end
                        end
                        ST_UVAL: begin
                            if (ws || i_byte == C_GT) begin
                                e_v = ctx.key_pending;
                                e_kind = K_ATTR_END;
                                ctx.key_pending = 1'b0;
                                ctx.pstate = ST_AWS;
                                done = 1'b0;
                            end else if (ctx.key_pending) begin
                                e_v = 1'b1;
                                e_kind = K_VALUE;
                                e_byte = i_byte;
                            end
                        end
                        ST_POST: begin
                            if (i_byte == C_SL) begin
                                ctx.pstate = ST_SLASH;
                            end else begin
                                e_v = 1'b1;
                                e_kind = K_START;
                                ctx.pstate = ST_TEXT;
                                done = (i_byte == C_GT);
                            end
                        end
                        ST_SLASH: begin
                            e_v = 1'b1;
                            e_kind = K_EMPTY;
                            ctx.pstate = ST_TEXT;
                            done = (i_byte == C_GT);
                        end
                        ST_DTAIL: begin
                            if (i_byte == C_GT) begin
                                e_v = 1'b1;
                                e_kind = K_DECL;
                                ctx.pstate = ST_TEXT;
                            end
                        end
                        default: begin
                            ctx.pstate = ST_TEXT;
                            done = 1'b0;
                        end
                    endcase
                    if (e_v && n != 2'd3) begin
                        res[n].kind = e_kind;
                        res[n].data = e_byte;
                        n = n + 2'd1;
                    end
                end
            end
        end
    end

    assign o_ctx     = ctx;
    assign o_batch.n = n;
    assign o_batch.r = res;

endmodule

FILE: design/xmt_outq.sv
// Result buffer: holds one byte's tokens and hands them out one per beat.
module xmt_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  xmt_pkg::t_batch i_batch,
    input  logic            i_ready,
    output logic            o_can_load,
    output logic            o_valid,
    output xmt_pkg::t_res   o_res,
    output logic            o_last
);
    import xmt_pkg::*;

    logic [1:0]          r_cnt;
    t_res [MAX_RES-1:0]  r_q;
    logic                pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_res      = r_q[0];
    assign o_last     = (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.n;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Advance the head on each beat taken.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_batch.r;
        end else if (pop) begin
            r_q <= {t_res'('0), r_q[MAX_RES-1:1]};
        end
    end

endmodule

FILE: test/testbench.sv
// Testbench for the streaming markup tokenizer: directed and random byte streams.
`timescale 1ns / 1ps
module testbench;
    import xmt_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_xml_token;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_stream = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [3:0] o_token_kind;
    logic [7:0] o_out_byte;
    logic       o_last;

    // Tokenizer context as the parser should hold it after each accepted beat.
    t_pstate    tok_state;
    logic       tok_text_open;
    logic       tok_key_open;
    logic       tok_single_quote;
    logic       tok_in_decl;

    t_xml_token token_batch[$];
    t_xml_token expected_tokens[$];
    int         mismatch_count = 0;
    int         bytes_sent = 0;
    logic       steady_flow = 1'b0;

    // Random tag cut short by an end of stream.
    int         tag_len;
    int         tag_cut_at;
    logic       tag_cut;

    xml_markup_tokenizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_token_kind    (o_token_kind),
        .o_out_byte      (o_out_byte),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (steady_flow) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void reset_tokenizer();
        tok_state        = ST_TEXT;
        tok_text_open    = 1'b0;
        tok_key_open     = 1'b0;
        tok_single_quote = 1'b0;
        tok_in_decl      = 1'b0;
    endfunction

    function automatic void put_token(input t_kind kind, input logic [7:0] data);
        t_xml_token tok;
        if (token_batch.size() < MAX_RES) begin
            tok.kind = kind;
            tok.data = data;
            tok.last = 1'b0;
            token_batch.push_back(tok);
        end
    endfunction

    // Attributes with an empty key never report their end.
    function automatic void close_attr();
        if (tok_key_open) put_token(K_ATTR_END, 8'h00);
        tok_key_open = 1'b0;
    endfunction

    function automatic void predict_tokens(input logic [7:0] c, input logic eos);
        logic settled;
        int   guard;
        token_batch.delete();
        if (eos) begin
            case (tok_state)
                ST_TEXT: begin
                    if (tok_text_open) put_token(K_TEXT_END, 8'h00);
                end
                ST_LT, ST_SNAME: put_token(K_START, 8'h00);
                ST_DNAME, ST_DTAIL: put_token(K_DECL, 8'h00);
                ST_ENAME: put_token(K_ENDTAG, 8'h00);
                ST_SLASH: put_token(K_EMPTY, 8'h00);
                default: begin
                    close_attr();
                    put_token(tok_in_decl ? K_DECL : K_START, 8'h00);
                end
            endcase
            reset_tokenizer();
        end else begin
            settled = 1'b0;
            for (guard = 0; guard < 8 && !settled; guard++) begin
                settled = 1'b1;
                case (tok_state)
                    ST_TEXT: begin
                        if (c == C_LT) begin
                            if (tok_text_open) put_token(K_TEXT_END, 8'h00);
                            tok_text_open = 1'b0;
                            tok_state = ST_LT;
                        end else begin
                            put_token(K_TEXT, c);
                            tok_text_open = 1'b1;
                        end
                    end
                    ST_LT: begin
                        if (c == C_QM) begin
                            tok_in_decl = 1'b1;
                            tok_state = ST_DNAME;
                        end else if (c == C_SL) begin
                            tok_state = ST_ENAME;
                        end else begin
                            tok_in_decl = 1'b0;
                            tok_state = ST_SNAME;
                            settled = 1'b0;
                        end
                    end
                    ST_DNAME: begin
                        if (is_blank(c) || c == C_QM) begin
                            tok_state = ST_AWS;
                            settled = 1'b0;
                        end else begin
                            put_token(K_NAME, c);
                        end
                    end
                    ST_ENAME: begin
                        if (c == C_GT) begin
                            put_token(K_ENDTAG, 8'h00);
                            tok_state = ST_TEXT;
                        end else if (!is_blank(c)) begin
                            put_token(K_NAME, c);
                        end
                    end
                    ST_SNAME: begin
                        if (is_blank(c) || c == C_GT || c == C_SL) begin
                            tok_state = ST_AWS;
                            settled = 1'b0;
                        end else begin
                            put_token(K_NAME, c);
                        end
                    end
                    ST_AWS: begin
                        if (!is_blank(c)) begin
                            if (c == C_GT || c == C_QM || c == C_SL) begin
                                tok_state = tok_in_decl ? ST_DTAIL : ST_POST;
                            end else begin
                                tok_key_open = 1'b0;
                                tok_state = ST_KEY;
                            end
                            settled = 1'b0;
                        end
                    end
                    ST_KEY: begin
                        if (is_blank(c) || c == C_EQ || c == C_GT || c == C_SL
                                || c == C_QM) begin
                            tok_state = ST_KWS;
                            settled = 1'b0;
                        end else begin
                            put_token(K_KEY, c);
                            tok_key_open = 1'b1;
                        end
                    end
                    ST_KWS: begin
                        if (c == C_EQ) begin
                            tok_state = ST_EWS;
                        end else if (!is_blank(c)) begin
                            close_attr();
                            tok_state = ST_AWS;
                            settled = 1'b0;
                        end
                    end
                    ST_EWS: begin
                        if (c == C_DQ || c == C_SQ) begin
                            tok_single_quote = (c == C_SQ);
                            tok_state = ST_QVAL;
                        end else if (!is_blank(c)) begin
                            tok_state = ST_UVAL;
                            settled = 1'b0;
                        end
                    end
                    ST_QVAL: begin
                        if (c == (tok_single_quote ? C_SQ : C_DQ)) begin
                            close_attr();
                            tok_state = ST_AWS;
                        end else if (tok_key_open) begin
                            put_token(K_VALUE, c);
                        end
                    end
                    ST_UVAL: begin
                        if (is_blank(c) || c == C_GT) begin
                            close_attr();
                            tok_state = ST_AWS;
                            settled = 1'b0;
                        end else if (tok_key_open) begin
                            put_token(K_VALUE, c);
                        end
                    end
                    ST_POST: begin
                        if (c == C_SL) begin
                            tok_state = ST_SLASH;
                        end else begin
                            put_token(K_START, 8'h00);
                            tok_state = ST_TEXT;
                            if (c != C_GT) settled = 1'b0;
                        end
                    end
                    ST_SLASH: begin
                        put_token(K_EMPTY, 8'h00);
                        tok_state = ST_TEXT;
                        if (c != C_GT) settled = 1'b0;
                    end
                    ST_DTAIL: begin
                        if (c == C_GT) begin
                            put_token(K_DECL, 8'h00);
                            tok_state = ST_TEXT;
                        end
                    end
                    default: begin
                        tok_state = ST_TEXT;
                        settled = 1'b0;
                    end
                endcase
            end
        end
        if (token_batch.size() > 0) token_batch[token_batch.size() - 1].last = 1'b1;
        foreach (token_batch[i]) expected_tokens.push_back(token_batch[i]);
    endfunction

    // Compare every accepted token beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_xml_token want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_tokens.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected token: kind %0d byte %02h last %0b",
                             o_token_kind, o_out_byte, o_last);
            end else begin
                want = expected_tokens.pop_front();
                if (o_token_kind !== want.kind || o_out_byte !== want.data
                        || o_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                                 want.kind, want.data, want.last,
                                 o_token_kind, o_out_byte, o_last);
                end
            end
        end
    end

    // Hold valid and payload until the beat is taken, then predict its tokens.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while (!steady_flow && $urandom_range(0, 99) < 33) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (!o_ready);
        predict_tokens(b, eos);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h21, 8'hFF));
        while (b == C_LT || b == C_QM || b == C_SL || b == C_GT || b == C_EQ
               || b == C_DQ || b == C_SQ);
        return b;
    endfunction

    function automatic logic [7:0] blank_char();
        logic [7:0] b;
        b = 8'($urandom_range(8'h08, 8'h0D));
        return (b == 8'h08) ? 8'h20 : b;
    endfunction

    function automatic logic [7:0] markup_char();
        case ($urandom_range(0, 9))
            0: return C_LT;
            1: return C_QM;
            2: return C_SL;
            3: return C_GT;
            4: return C_EQ;
            5: return C_DQ;
            6: return C_SQ;
            7: return blank_char();
            default: return name_char();
        endcase
    endfunction

    // One byte of a random tag; drop the rest once the tag is cut by end of stream.
    task automatic tag_byte(input logic [7:0] b);
        if (!tag_cut) begin
            tag_len++;
            if (tag_len == tag_cut_at) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                tag_cut = 1'b1;
            end else begin
                send_byte(b, 1'b0);
            end
        end
    endtask

    task automatic send_random_tag();
        int         flavour;
        int         n;
        int         attrs;
        logic [7:0] quote;
        logic [7:0] b;
        tag_len = 0;
        tag_cut = 1'b0;
        tag_cut_at = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 8) : 0;
        flavour = $urandom_range(0, 5);
        tag_byte(C_LT);
        if (flavour == 4) begin
            tag_byte(C_SL);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0) tag_byte(blank_char());
                tag_byte(name_char());
            end
            tag_byte(C_GT);
        end else begin
            if (flavour == 5) tag_byte(C_QM);
            repeat ($urandom_range(1, 3)) tag_byte(name_char());
            attrs = $urandom_range(0, 2);
            repeat (attrs) begin
                repeat ($urandom_range(1, 2)) tag_byte(blank_char());
                if ($urandom_range(0, 99) >= 15) begin
                    repeat ($urandom_range(1, 3)) tag_byte(name_char());
                end
                if ($urandom_range(0, 99) < 80) begin
                    if ($urandom_range(0, 3) == 0) tag_byte(blank_char());
                    tag_byte(C_EQ);
                    if ($urandom_range(0, 3) == 0) tag_byte(blank_char());
                    if ($urandom_range(0, 99) < 60) begin
                        quote = $urandom_range(0, 1) ? C_SQ : C_DQ;
                        tag_byte(quote);
                        n = $urandom_range(0, 3);
                        repeat (n) begin
                            do b = 8'($urandom_range(0, 255)); while (b == quote);
                            tag_byte(b);
                        end
                        tag_byte(quote);
                    end else begin
                        repeat ($urandom_range(1, 3)) tag_byte(name_char());
                        if ($urandom_range(0, 2) == 0) tag_byte($urandom_range(0, 1) ? C_SL : C_QM);
                    end
                end
            end
            if (flavour == 5) begin
                if ($urandom_range(0, 1)) tag_byte(blank_char());
                tag_byte(C_QM);
                tag_byte(C_GT);
            end else begin
                case ($urandom_range(0, 4))
                    0, 1: tag_byte(C_GT);
                    2: begin
                        tag_byte(C_SL);
                        tag_byte(C_GT);
                    end
                    3: begin
                        tag_byte(blank_char());
                        tag_byte(C_SL);
                    end
                    default: begin
                        tag_byte(blank_char());
                        tag_byte(C_QM);
                    end
                endcase
            end
        end
    endtask

    // Declaration whose name swallows a '>', unquoted value holding a '?'.
    task automatic test_declaration();
        send_text("<?> k=1?>");
    endtask

    // Blanks inside an end tag are dropped.
    task automatic test_end_tag();
        send_text("</ a>");
    endtask

    // Empty key suppresses its value, then the byte after a stray slash closes the tag as empty.
    task automatic test_empty_key_and_stray_slash();
        send_text("<a ='");
        send_byte(8'hFF, 1'b0);
        send_text("'/");
        send_byte(8'h00, 1'b0);
    endtask

    // A stray '?' ends the key and the start tag in one beat, then flush the text.
    task automatic test_stray_question_and_flush();
        send_text("<a k?");
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_random_stream();
        int         goal;
        logic [7:0] b;
        goal = bytes_sent + 136;
        steady_flow = 1'b1;
        while (bytes_sent < goal) begin
            if (bytes_sent >= goal - 90) steady_flow = 1'b0;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    repeat ($urandom_range(1, 4)) begin
                        do b = 8'($urandom_range(0, 255)); while (b == C_LT);
                        send_byte(b, 1'b0);
                    end
                end
                6, 7, 8, 9, 10, 11, 12, 13, 14: send_random_tag();
                15, 16, 17: begin
                    repeat ($urandom_range(1, 4)) send_byte(markup_char(), 1'b0);
                end
                default: send_byte(8'($urandom_range(0, 255)), 1'b1);
            endcase
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        reset_tokenizer();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_declaration();
        test_end_tag();
        test_empty_key_and_stray_slash();
        test_stray_question_and_flush();
        test_random_stream();
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: xml_markup_tokenizer.f
+incdir+design
design/xmt_pkg.sv
design/xmt_step.sv
design/xmt_outq.sv
design/xml_markup_tokenizer.sv
test/testbench.sv
